// ----- sv/flwc_pkg.sv -----
`timescale 1ns / 1ps

package flwc_pkg;

  // Geometry of the flash part
  localparam int MAX_BLOCKS      = 1024;
  localparam int PAGES_PER_BLOCK = 64;
  localparam int PAGE_MAIN_BYTES = 4096;
  localparam int HEADER_BYTES    = 12;

  // Upper bound on candidates tried by one next-good-block walk
  localparam int SEARCH_LIMIT = 2050;

  localparam int BLK_W   = $clog2(MAX_BLOCKS);
  localparam int PAGE_W  = $clog2(PAGES_PER_BLOCK);
  localparam int SEQ_W   = 32;
  localparam int LEN_W   = 16;
  localparam int ACT_W   = 2;
  localparam int STAT_W  = 2;
  localparam int CNT_W   = $clog2(SEARCH_LIMIT + 1);
  localparam int CFG_IDX_W = 1;

  // Actions
  localparam logic [ACT_W-1:0] ACT_MARK   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_APPEND = 2'd1;
  localparam logic [ACT_W-1:0] ACT_SET    = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOTREADY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_LONG     = 2'd2;
  localparam logic [STAT_W-1:0] STAT_NOGOOD   = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FIRST = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LAST  = 1'd1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_RD,
    ST_CHK,
    ST_DONE
  } state_e;

  // Control of the block walk unit
  typedef struct packed {
    logic load;
    logic step;
  } walk_ctrl_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [BLK_W-1:0]  rblk;
    logic [PAGE_W-1:0] rpage;
    logic [SEQ_W-1:0]  rseq;
    logic              ereq;
    logic [BLK_W-1:0]  eblk;
  } result_t;

endpackage

// ----- sv/flwc_ram.sv -----
`timescale 1ns / 1ps

module flwc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/flwc_walk.sv -----
`timescale 1ns / 1ps

// Ring walker: one candidate block per step, wrap past last to first.
module flwc_walk (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  flwc_pkg::walk_ctrl_t      ctrl_i,
  input  logic [flwc_pkg::BLK_W-1:0] start_block_i,
  input  logic [flwc_pkg::BLK_W-1:0] first_block_i,
  input  logic [flwc_pkg::BLK_W-1:0] last_block_i,
  output logic [flwc_pkg::BLK_W-1:0] cand_o,
  output logic [flwc_pkg::BLK_W-1:0] cand_next_o,
  output logic                      exhausted_o
);

  logic [flwc_pkg::BLK_W-1:0] cand_q;
  logic [flwc_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [flwc_pkg::BLK_W:0]   cand_inc;
  logic                       wrap;

  assign cand_inc    = {1'b0, cand_q} + (flwc_pkg::BLK_W+1)'(1);
  assign wrap        = cand_inc > {1'b0, last_block_i};
  assign cand_next_o = wrap ? first_block_i : cand_inc[flwc_pkg::BLK_W-1:0];

  always_comb begin
    cnt_d = cnt_q;
    if (ctrl_i.load) begin
      cnt_d = '0;
    end else if (ctrl_i.step) begin
      cnt_d = cnt_q + flwc_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cand_q <= start_block_i;
    end else if (ctrl_i.step) begin
      cand_q <= cand_next_o;
    end
  end

  assign cand_o      = cand_q;
  assign exhausted_o = cnt_q == flwc_pkg::CNT_W'(flwc_pkg::SEARCH_LIMIT);

endmodule

// ----- sv/flash_log_write_cursor.sv -----
`timescale 1ns / 1ps

// Write cursor for a flash log ring between first_block and last_block.
// Input channel (in_valid_i / in_stall_o) takes one action item: mark a
// block bad or good, append a record, or set cursor and sequence. Output
// channel (out_valid_o / out_stall_i) returns exactly one result item per
// input item. Config registers first_block / last_block are written via
// cfg_we_i / cfg_index_i / cfg_data_i; the user must write them only while
// the block is idle, as the block itself does not enforce this.
// Sequence: mark, set position, rejected appends and appends that stay in
// the current block go from EXEC to DONE, which loads the result into the
// output register and raises the result valid, then back to idle, where the
// next item can be accepted. An append that leaves its block walks the ring
// for the next good block through the bad-block RAM, a RAM read (RD) and then
// a check (CHK) per candidate, for at most 2050 candidates (then status 3).
// One item is in flight at a time; in_stall_o is high until it finishes.
// Reset: the bad-block RAM is cleared by a pass over all 1024 blocks, one
// block a cycle, with in_stall_o high; config writes are still taken.
// A stalled result sits in the output register; the next item can be
// accepted meanwhile and waits in its final state until the register frees.
module flash_log_write_cursor (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Config port
  input  logic                            cfg_we_i,
  input  logic [flwc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [flwc_pkg::BLK_W-1:0]      cfg_data_i,
  // Input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [flwc_pkg::ACT_W-1:0]      action_i,
  input  logic [flwc_pkg::BLK_W-1:0]      block_index_i,
  input  logic                            bad_flag_i,
  input  logic [flwc_pkg::PAGE_W-1:0]     page_index_i,
  input  logic [flwc_pkg::LEN_W-1:0]      record_length_i,
  input  logic [flwc_pkg::SEQ_W-1:0]      sequence_start_i,
  // Output channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [flwc_pkg::STAT_W-1:0]     status_o,
  output logic [flwc_pkg::BLK_W-1:0]      record_block_o,
  output logic [flwc_pkg::PAGE_W-1:0]     record_page_o,
  output logic [flwc_pkg::SEQ_W-1:0]      record_sequence_o,
  output logic                            erase_request_o,
  output logic [flwc_pkg::BLK_W-1:0]      erase_block_index_o
);

  flwc_pkg::state_e state_q, state_d;

  // Config
  logic [flwc_pkg::BLK_W-1:0] first_q, last_q;

  // Cursor state
  logic [flwc_pkg::BLK_W-1:0]  cur_blk_q, cur_blk_d;
  logic [flwc_pkg::PAGE_W-1:0] cur_page_q, cur_page_d;
  logic [flwc_pkg::SEQ_W-1:0]  seq_q, seq_d;
  logic                        pos_valid_q, pos_valid_d;

  // Clear-pass counter
  logic [flwc_pkg::BLK_W-1:0] clr_q, clr_d;

  // Captured item
  logic [flwc_pkg::ACT_W-1:0]  act_q;
  logic [flwc_pkg::BLK_W-1:0]  blk_q;
  logic                        flag_q;
  logic [flwc_pkg::PAGE_W-1:0] page_q;
  logic [flwc_pkg::LEN_W-1:0]  len_q;
  logic [flwc_pkg::SEQ_W-1:0]  sstart_q;

  // Result staging and output register
  flwc_pkg::result_t res_q, res_d, out_q;
  logic              out_valid_q;
  logic              out_load;

  // Bad-block RAM
  logic                       ram_we, ram_re;
  logic [flwc_pkg::BLK_W-1:0] ram_waddr;
  logic [0:0]                 ram_wdata, ram_rdata;

  // Walk unit
  flwc_pkg::walk_ctrl_t       walk_ctrl;
  logic [flwc_pkg::BLK_W-1:0] walk_cand, walk_cand_next;
  logic                       walk_exhausted;

  logic                        in_acc;
  logic [flwc_pkg::PAGE_W:0]   page_inc;
  logic                        page_end;
  logic [flwc_pkg::LEN_W:0]    len_sum;
  logic                        too_long;

  assign in_stall_o = state_q != flwc_pkg::ST_IDLE;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign page_inc = {1'b0, cur_page_q} + (flwc_pkg::PAGE_W+1)'(1);
  assign page_end = page_inc >= (flwc_pkg::PAGE_W+1)'(flwc_pkg::PAGES_PER_BLOCK);
  assign len_sum  = {1'b0, len_q} + (flwc_pkg::LEN_W+1)'(flwc_pkg::HEADER_BYTES);
  assign too_long = len_sum > (flwc_pkg::LEN_W+1)'(flwc_pkg::PAGE_MAIN_BYTES);

  flwc_ram #(
    .WIDTH(1),
    .DEPTH(flwc_pkg::MAX_BLOCKS)
  ) u_bad_map (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(walk_cand_next),
    .rdata_o(ram_rdata)
  );

  flwc_walk u_walk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (walk_ctrl),
    .start_block_i(cur_blk_q),
    .first_block_i(first_q),
    .last_block_i (last_q),
    .cand_o       (walk_cand),
    .cand_next_o  (walk_cand_next),
    .exhausted_o  (walk_exhausted)
  );

  // Sequencer
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    cur_blk_d   = cur_blk_q;
    cur_page_d  = cur_page_q;
    seq_d       = seq_q;
    pos_valid_d = pos_valid_q;
    res_d       = res_q;
    ram_we      = 1'b0;
    ram_waddr   = clr_q;
    ram_wdata   = 1'b0;
    ram_re      = 1'b0;
    walk_ctrl   = '0;
    out_load    = 1'b0;

    case (state_q)
      flwc_pkg::ST_CLEAR: begin
        ram_we = 1'b1;
        clr_d  = clr_q + flwc_pkg::BLK_W'(1);
        if (clr_q == flwc_pkg::BLK_W'(flwc_pkg::MAX_BLOCKS - 1)) begin
          state_d = flwc_pkg::ST_IDLE;
        end
      end

      flwc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = flwc_pkg::ST_EXEC;
        end
      end

      flwc_pkg::ST_EXEC: begin
        res_d   = '0;
        state_d = flwc_pkg::ST_DONE;
        case (act_q)
          flwc_pkg::ACT_MARK: begin
            ram_we    = 1'b1;
            ram_waddr = blk_q;
            ram_wdata = flag_q;
          end
          flwc_pkg::ACT_SET: begin
            cur_blk_d   = blk_q;
            cur_page_d  = page_q;
            seq_d       = sstart_q;
            pos_valid_d = 1'b1;
          end
          flwc_pkg::ACT_APPEND: begin
            if (!pos_valid_q || len_q == '0) begin
              res_d.status = flwc_pkg::STAT_NOTREADY;
            end else if (!page_end) begin
              // Stays in the current block
              cur_page_d   = page_inc[flwc_pkg::PAGE_W-1:0];
              seq_d        = seq_q + flwc_pkg::SEQ_W'(1);
              res_d.rblk   = cur_blk_q;
              res_d.rseq   = seq_q;
              res_d.rpage  = too_long ? page_inc[flwc_pkg::PAGE_W-1:0] : cur_page_q;
              res_d.status = too_long ? flwc_pkg::STAT_LONG : flwc_pkg::STAT_OK;
            end else begin
              walk_ctrl.load = 1'b1;
              state_d        = flwc_pkg::ST_RD;
            end
          end
          default: begin
            res_d.status = flwc_pkg::STAT_NOTREADY;
          end
        endcase
      end

      flwc_pkg::ST_RD: begin
        ram_re         = 1'b1;
        walk_ctrl.step = 1'b1;
        state_d        = flwc_pkg::ST_CHK;
      end

      flwc_pkg::ST_CHK: begin
        if (!ram_rdata[0]) begin
          // Good block found: enter it at page 0 and ask for an erase
          res_d      = '0;
          cur_blk_d  = walk_cand;
          cur_page_d = '0;
          seq_d      = seq_q + flwc_pkg::SEQ_W'(1);
          res_d.rseq = seq_q;
          res_d.ereq = 1'b1;
          res_d.eblk = walk_cand;
          if (too_long) begin
            res_d.status = flwc_pkg::STAT_LONG;
            res_d.rblk   = walk_cand;
          end else begin
            res_d.status = flwc_pkg::STAT_OK;
            res_d.rblk   = cur_blk_q;
            res_d.rpage  = cur_page_q;
          end
          state_d = flwc_pkg::ST_DONE;
        end else if (walk_exhausted) begin
          res_d        = '0;
          res_d.status = flwc_pkg::STAT_NOGOOD;
          state_d      = flwc_pkg::ST_DONE;
        end else begin
          state_d = flwc_pkg::ST_RD;
        end
      end

      flwc_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = flwc_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = flwc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= flwc_pkg::ST_CLEAR;
      clr_q       <= '0;
      cur_blk_q   <= '0;
      cur_page_q  <= '0;
      seq_q       <= flwc_pkg::SEQ_W'(1);
      pos_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cur_blk_q   <= cur_blk_d;
      cur_page_q  <= cur_page_d;
      seq_q       <= seq_d;
      pos_valid_q <= pos_valid_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= '0;
      last_q  <= flwc_pkg::BLK_W'(flwc_pkg::MAX_BLOCKS - 1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        flwc_pkg::REG_FIRST: first_q <= cfg_data_i;
        flwc_pkg::REG_LAST:  last_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Payload capture, result staging and output register, no reset
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q    <= action_i;
      blk_q    <= block_index_i;
      flag_q   <= bad_flag_i;
      page_q   <= page_index_i;
      len_q    <= record_length_i;
      sstart_q <= sequence_start_i;
    end
    res_q <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign status_o            = out_q.status;
  assign record_block_o      = out_q.rblk;
  assign record_page_o       = out_q.rpage;
  assign record_sequence_o   = out_q.rseq;
  assign erase_request_o     = out_q.ereq;
  assign erase_block_index_o = out_q.eblk;

  // No result may appear while the bad-block RAM is still being cleared
  a_no_out_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == flwc_pkg::ST_CLEAR |-> !out_valid_o)
    else $error("result valid during clear pass");

  // A failed walk reports nothing but its status
  a_nogood_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == flwc_pkg::STAT_NOGOOD |->
      record_block_o == '0 && record_sequence_o == '0 && !erase_request_o)
    else $error("no-good-block result carries data");

  // Oversized record that opened a block lands on page 0 of the erased block
  a_long_erase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && erase_request_o && status_o == flwc_pkg::STAT_LONG |->
      erase_block_index_o == record_block_o && record_page_o == '0)
    else $error("oversized record not on erased block");

  // A good candidate moves the cursor to it
  a_cursor_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == flwc_pkg::ST_CHK && !ram_rdata[0] |=>
      cur_page_q == '0 && cur_blk_q == $past(walk_cand))
    else $error("cursor did not move to found block");

  // Once set, the position stays valid until reset
  a_pos_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(pos_valid_q))
    else $error("position valid dropped");

endmodule
